// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define LCDSEQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define LCDSEQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lcdseq_pkg.sv =====
// types and constants of the character lcd nibble sequencer
package lcdseq_pkg;

  localparam int NUM_INIT_CMDS = 5;
  localparam logic [2:0] PHASE_CHARS = 3'd5;

  // opcodes of a request
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // request status codes
  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_REFUSED  = 2'd1;
  localparam logic [1:0] STATUS_TICK     = 2'd2;

  // register indexes
  localparam logic [2:0] REG_HOME         = 3'd0;
  localparam logic [2:0] REG_FUNCTION_SET = 3'd1;
  localparam logic [2:0] REG_DISPLAY_ON   = 3'd2;
  localparam logic [2:0] REG_CLEAR        = 3'd3;
  localparam logic [2:0] REG_ENTRY_MODE   = 3'd4;
  localparam logic [2:0] REG_SETTLE       = 3'd5;

  // register reset values
  localparam logic [7:0] RST_HOME         = 8'd2;
  localparam logic [7:0] RST_FUNCTION_SET = 8'd40;
  localparam logic [7:0] RST_DISPLAY_ON   = 8'd12;
  localparam logic [7:0] RST_CLEAR        = 8'd1;
  localparam logic [7:0] RST_ENTRY_MODE   = 8'd6;
  localparam logic [7:0] RST_SETTLE       = 8'd2;

  typedef enum logic [4:0] {
    SUB_HI     = 5'b00001,
    SUB_HI_OFF = 5'b00010,
    SUB_LO     = 5'b00100,
    SUB_LO_OFF = 5'b01000,
    SUB_WAIT   = 5'b10000
  } sub_step_t;

  typedef struct packed {
    logic [NUM_INIT_CMDS-1:0][7:0] cmds;
    logic [7:0]                    settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] bus_nibble;
    logic       reg_select;
    logic       e_strobe;
    logic       ready_res;
    logic       request_free;
    logic [1:0] request_status;
  } res_t;

endpackage

// ===== src/lcdseq_if.sv =====
// request and result channel interfaces
interface lcdseq_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] char_code;

  modport source (output valid, output opcode, output char_code, input ready);
  modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface lcdseq_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] bus_nibble;
  logic       reg_select;
  logic       e_strobe;
  logic       ready_res;
  logic       request_free;
  logic [1:0] request_status;

  modport source (
    output valid, output bus_nibble, output reg_select, output e_strobe,
    output ready_res, output request_free, output request_status, input ready
  );
  modport sink (
    input valid, input bus_nibble, input reg_select, input e_strobe,
    input ready_res, input request_free, input request_status, output ready
  );
endinterface

// ===== src/lcdseq_cfg.sv =====
// apb register file: init commands and settle time
module lcdseq_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output lcdseq_pkg::cfg_t    cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cmds[0]      <= lcdseq_pkg::RST_HOME;
      cfg.cmds[1]      <= lcdseq_pkg::RST_FUNCTION_SET;
      cfg.cmds[2]      <= lcdseq_pkg::RST_DISPLAY_ON;
      cfg.cmds[3]      <= lcdseq_pkg::RST_CLEAR;
      cfg.cmds[4]      <= lcdseq_pkg::RST_ENTRY_MODE;
      cfg.settle_ticks <= lcdseq_pkg::RST_SETTLE;
    end else if (wr_en) begin
      unique case (reg_idx)
        lcdseq_pkg::REG_HOME:         cfg.cmds[0]      <= pwdata[7:0];
        lcdseq_pkg::REG_FUNCTION_SET: cfg.cmds[1]      <= pwdata[7:0];
        lcdseq_pkg::REG_DISPLAY_ON:   cfg.cmds[2]      <= pwdata[7:0];
        lcdseq_pkg::REG_CLEAR:        cfg.cmds[3]      <= pwdata[7:0];
        lcdseq_pkg::REG_ENTRY_MODE:   cfg.cmds[4]      <= pwdata[7:0];
        lcdseq_pkg::REG_SETTLE:       cfg.settle_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      lcdseq_pkg::REG_HOME:         prdata = {24'd0, cfg.cmds[0]};
      lcdseq_pkg::REG_FUNCTION_SET: prdata = {24'd0, cfg.cmds[1]};
      lcdseq_pkg::REG_DISPLAY_ON:   prdata = {24'd0, cfg.cmds[2]};
      lcdseq_pkg::REG_CLEAR:        prdata = {24'd0, cfg.cmds[3]};
      lcdseq_pkg::REG_ENTRY_MODE:   prdata = {24'd0, cfg.cmds[4]};
      lcdseq_pkg::REG_SETTLE:       prdata = {24'd0, cfg.settle_ticks};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/lcdseq_seq.sv =====
// sequencer state and its single-step update for one request
module lcdseq_seq (
  input  logic              clk,
  input  logic              rst,
  input  lcdseq_pkg::cfg_t  cfg,
  input  logic              step,
  input  logic              opcode,
  input  logic [7:0]        char_code,
  output lcdseq_pkg::res_t  result
);

  logic [2:0]              phase, phase_next;
  lcdseq_pkg::sub_step_t   sub_step, sub_step_next;
  logic [7:0]              wait_count, wait_count_next;
  logic                    pending, pending_next;
  logic [7:0]              held_char, held_char_next;
  logic                    init_done, init_done_next;
  logic [3:0]              pin_nibble, pin_nibble_next;
  logic                    pin_rs, pin_rs_next;
  logic                    pin_e, pin_e_next;
  logic [1:0]              status;
  logic                    in_init;
  logic                    byte_done;
  logic [7:0]              cur_byte;

  assign in_init = phase < lcdseq_pkg::PHASE_CHARS;

  always_comb begin
    case (phase)
      3'd0:    cur_byte = cfg.cmds[0];
      3'd1:    cur_byte = cfg.cmds[1];
      3'd2:    cur_byte = cfg.cmds[2];
      3'd3:    cur_byte = cfg.cmds[3];
      3'd4:    cur_byte = cfg.cmds[4];
      default: cur_byte = held_char;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    sub_step_next   = sub_step;
    wait_count_next = wait_count;
    pending_next    = pending;
    held_char_next  = held_char;
    init_done_next  = init_done;
    pin_nibble_next = pin_nibble;
    pin_rs_next     = pin_rs;
    pin_e_next      = pin_e;
    status          = lcdseq_pkg::STATUS_TICK;
    byte_done       = 1'b0;

    if (opcode == lcdseq_pkg::OP_WRITE) begin
      if (init_done && !pending) begin
        pending_next   = 1'b1;
        held_char_next = char_code;
        status         = lcdseq_pkg::STATUS_ACCEPTED;
      end else begin
        status = lcdseq_pkg::STATUS_REFUSED;
      end
    end else if (in_init || pending) begin
      unique case (sub_step)
        lcdseq_pkg::SUB_HI: begin
          pin_nibble_next = cur_byte[7:4];
          pin_rs_next     = !in_init;
          pin_e_next      = 1'b1;
          sub_step_next   = lcdseq_pkg::SUB_HI_OFF;
        end
        lcdseq_pkg::SUB_HI_OFF: begin
          pin_e_next    = 1'b0;
          sub_step_next = lcdseq_pkg::SUB_LO;
        end
        lcdseq_pkg::SUB_LO: begin
          pin_nibble_next = cur_byte[3:0];
          pin_rs_next     = !in_init;
          pin_e_next      = 1'b1;
          sub_step_next   = lcdseq_pkg::SUB_LO_OFF;
        end
        lcdseq_pkg::SUB_LO_OFF: begin
          pin_e_next    = 1'b0;
          sub_step_next = lcdseq_pkg::SUB_WAIT;
        end
        lcdseq_pkg::SUB_WAIT: begin
          // counter wraps when settle is zero or was lowered mid-wait
          wait_count_next = wait_count + 8'd1;
          if (wait_count_next == cfg.settle_ticks) begin
            wait_count_next = 8'd0;
            sub_step_next   = lcdseq_pkg::SUB_HI;
            byte_done       = 1'b1;
          end
        end
        default: sub_step_next = lcdseq_pkg::SUB_HI;
      endcase

      if (byte_done) begin
        if (in_init) begin
          phase_next = phase + 3'd1;
          if (phase_next == lcdseq_pkg::PHASE_CHARS) begin
            init_done_next = 1'b1;
          end
        end else begin
          pending_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 3'd0;
      sub_step   <= lcdseq_pkg::SUB_HI;
      wait_count <= 8'd0;
      pending    <= 1'b0;
      held_char  <= 8'd0;
      init_done  <= 1'b0;
      pin_nibble <= 4'd0;
      pin_rs     <= 1'b0;
      pin_e      <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      sub_step   <= sub_step_next;
      wait_count <= wait_count_next;
      pending    <= pending_next;
      held_char  <= held_char_next;
      init_done  <= init_done_next;
      pin_nibble <= pin_nibble_next;
      pin_rs     <= pin_rs_next;
      pin_e      <= pin_e_next;
    end
  end

  assign result.bus_nibble     = pin_nibble_next;
  assign result.reg_select     = pin_rs_next;
  assign result.e_strobe       = pin_e_next;
  assign result.ready_res      = init_done_next;
  assign result.request_free   = !pending_next;
  assign result.request_status = status;

endmodule

// ===== src/char_lcd_nibble_sequencer.sv =====
// Character LCD sequencer for a 4-bit bus, driven one tick or write request at a time.
// Request channel (cmd): opcode 0 is a tick, opcode 1 asks to write char_code.
// Result channel (res): one result per request with the pin levels after the
// update, init status, whether a write is pending and the request status.
// Configuration: APB registers for the five init commands and settle time; the user
// must write them only while no request is in flight; the block does not enforce this.
// Accepted requests enter the input register; results leave from the result register.
// Throughput: one request per cycle unless the result side stalls; the state update
// is one short combinational step between the input register and the result register.
// A stalled result register holds its value; the input register still takes one
// more request, and cmd.ready drops only while both registers are full.
// Reset: empties both registers, restores the register defaults and restarts
// the init command sequence from the first command.
module char_lcd_nibble_sequencer (
  input  logic                clk,
  input  logic                rst,
  lcdseq_req_if.sink          cmd,
  lcdseq_res_if.source        res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  lcdseq_pkg::cfg_t cfg;
  lcdseq_pkg::res_t step_result;
  lcdseq_pkg::res_t out_data;

  logic       in_valid;
  logic       in_opcode;
  logic [7:0] in_char;
  logic       out_valid;
  logic       advance;

  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  lcdseq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcdseq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (advance),
    .opcode    (in_opcode),
    .char_code (in_char),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_opcode <= cmd.opcode;
      in_char   <= cmd.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

  assign res.valid          = out_valid;
  assign res.bus_nibble     = out_data.bus_nibble;
  assign res.reg_select     = out_data.reg_select;
  assign res.e_strobe       = out_data.e_strobe;
  assign res.ready_res      = out_data.ready_res;
  assign res.request_free   = out_data.request_free;
  assign res.request_status = out_data.request_status;

endmodule

// ===== src/lcdseq_checker.sv =====
// port-level checks for the lcd sequencer and their bind
`include "assert_macros.svh"

module lcdseq_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_status,
  input logic       res_ready_res,
  input logic       res_request_free
);

  // a result waiting at the port stays until taken
  `LCDSEQ_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid, "result dropped while stalled")

  // no result comes out in the cycle after reset
  `LCDSEQ_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !res_valid, "result valid right after reset")

  // an accepted write means init is done and the write is now pending
  `LCDSEQ_ASSERT(a_accept_pending, clk, rst, res_valid && (res_status == lcdseq_pkg::STATUS_ACCEPTED) |-> res_ready_res && !res_request_free, "accepted write without ready or pending")

  // request side stalls only behind a stalled result
  `LCDSEQ_ASSERT(a_stall_cause, clk, rst, !cmd_ready |-> res_valid && !res_ready, "request stalled with result side free")

endmodule

bind char_lcd_nibble_sequencer lcdseq_checker u_lcdseq_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_status       (res.request_status),
  .res_ready_res    (res.ready_res),
  .res_request_free (res.request_free)
);
